// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the ordered list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define OLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ole_pkg.sv -----
// Package for the ordered list engine: word types, operation and status codes.
package ole_pkg;

    localparam int OLE_CAPACITY = 16;
    localparam int OLE_SHIFT_W  = 16;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_DELETE  = 3'd1;
    localparam logic [2:0] OP_ROTATE  = 3'd2;
    localparam logic [2:0] OP_REVERSE = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]             func;
        logic [4:0]             position;
        logic signed [31:0]     value;
        logic [OLE_SHIFT_W-1:0] shift_amount;
    } t_in_word;

    typedef struct packed {
        logic [4:0]         entry_count;
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } t_out_word;

endpackage

// ----- hw/rtl/ordered_list_engine.sv -----
// Ordered list engine: a list of signed 32-bit values in one memory, with a sequencer.
//
// The engine keeps up to CAPACITY signed 32-bit values in order from the head, in a single
// memory with one write port and one registered read port, and runs one operation per input
// word: insert, delete, rotate, reverse, clear or read. Every word gives exactly one result
// word carrying the entry count, the read value and a status. The input stalls while an
// operation runs; the result sits in an output register, so the next word can be taken while
// a result still waits. Clear, failed checks, unused codes and rotate or reverse of an empty
// list go straight to the result; read waits on the registered read port; insert shifts the
// entries from position p up by one before it writes; delete shifts the entries after p down
// by one. Reverse of a nonempty list swaps pairs from the ends inward, each swapped pair an
// index check, two reads and two writes. Rotate first reduces the offset modulo n with a
// restoring divider that takes one bit per cycle, then turns the list with three range
// reversals; a zero effective offset ends after the divider. The single memory port pair
// sets every loop, one read and one write per element moved.
`include "assert_macros.svh"

module ordered_list_engine #(
    parameter int CAPACITY = ole_pkg::OLE_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ole_pkg::t_in_word i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ole_pkg::t_out_word o_out
);
    import ole_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = (CW > 5) ? CW : 5;
    localparam int SCW = $clog2(OLE_SHIFT_W);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_REV_CHK, S_RLO, S_RHI, S_WLO, S_WHI,
        S_SH_RD, S_SH_WR, S_INS_WR, S_DEL_RD, S_DEL_WR, S_RD_WAIT, S_RD_TAKE, S_DONE
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          r_pos;
    logic [31:0]            r_val;
    logic [OLE_SHIFT_W-1:0] r_dvd;
    logic [SCW-1:0]         r_step;
    logic [CW-1:0]          r_rem;
    logic [AW-1:0]          r_k;
    logic [AW-1:0]          r_lo;
    logic [AW-1:0]          r_hi;
    logic [AW-1:0]          r_shift;
    logic [1:0]             r_phase;
    logic [31:0]            r_tmp;
    logic [31:0]            r_rd;
    logic [1:0]             r_status;
    logic                   r_out_valid;
    t_out_word              r_out;

    logic [31:0]            r_mem [CAPACITY];
    logic [31:0]            r_rd_data;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [31:0]            mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;

    logic [PW-1:0]          pos_x;
    logic [PW-1:0]          cnt_x;
    logic [CW:0]            div_trial;
    logic [CW:0]            div_next;
    logic [CW-1:0]          rem_next;
    logic [AW-1:0]          last_idx;
    logic [CW:0]            k_ext;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        pos_x     = PW'(i_in.position);
        cnt_x     = PW'(r_count);
        last_idx  = AW'(r_count - CW'(1));
        k_ext     = (CW+1)'(r_k);
        // one restoring division step: shift in a dividend bit, subtract if it fits
        div_trial = {r_rem, r_dvd[OLE_SHIFT_W-1]};
        div_next  = (div_trial >= {1'b0, r_count}) ? (div_trial - {1'b0, r_count}) : div_trial;
        rem_next  = div_next[CW-1:0];
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_k;
        mem_wdata = r_rd_data;
        mem_re    = 1'b0;
        mem_raddr = r_k;
        case (r_state)
            S_SH_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_k - AW'(1);
            end
            S_SH_WR: begin
                mem_we    = 1'b1;
            end
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_val;
            end
            S_DEL_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_k + AW'(1);
            end
            S_DEL_WR: begin
                mem_we    = 1'b1;
            end
            S_RLO: begin
                mem_re    = 1'b1;
                mem_raddr = r_lo;
            end
            S_RHI: begin
                mem_re    = 1'b1;
                mem_raddr = r_hi;
            end
            S_WLO: begin
                mem_we    = 1'b1;
                mem_waddr = r_lo;
            end
            S_WHI: begin
                mem_we    = 1'b1;
                mem_waddr = r_hi;
                mem_wdata = r_tmp;
            end
            S_RD_WAIT: begin
                mem_re    = 1'b1;
                mem_raddr = r_pos;
            end
            default: begin
                mem_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_status <= ST_OK;
                        r_rd     <= '0;
                        r_pos    <= pos_x[AW-1:0];
                        r_val    <= i_in.value;
                        r_state  <= S_DONE;
                        case (i_in.func)
                            OP_INSERT: begin
                                if (pos_x > cnt_x) begin
                                    r_status <= ST_RANGE;
                                end else if (r_count == CW'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_k <= r_count[AW-1:0];
                                    if (r_count[AW-1:0] > pos_x[AW-1:0]) begin
                                        r_state <= S_SH_RD;
                                    end else begin
                                        r_state <= S_INS_WR;
                                    end
                                end
                            end
                            OP_DELETE: begin
                                if (pos_x >= cnt_x) begin
                                    r_status <= ST_RANGE;
                                end else begin
                                    r_k <= pos_x[AW-1:0];
                                    if (({1'b0, pos_x} + (PW+1)'(1)) < {1'b0, cnt_x}) begin
                                        r_state <= S_DEL_RD;
                                    end else begin
                                        r_count <= r_count - CW'(1);
                                    end
                                end
                            end
                            OP_ROTATE: begin
                                if (r_count != '0) begin
                                    r_dvd   <= i_in.shift_amount;
                                    r_rem   <= '0;
                                    r_step  <= SCW'(OLE_SHIFT_W - 1);
                                    r_state <= S_DIV;
                                end
                            end
                            OP_REVERSE: begin
                                if (r_count != '0) begin
                                    r_phase <= 2'd2;
                                    r_lo    <= '0;
                                    r_hi    <= last_idx;
                                    r_state <= S_REV_CHK;
                                end
                            end
                            OP_CLEAR: begin
                                r_count <= '0;
                            end
                            OP_READ: begin
                                if (pos_x >= cnt_x) begin
                                    r_status <= ST_RANGE;
                                end else begin
                                    r_state <= S_RD_WAIT;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem  <= rem_next;
                    r_dvd  <= {r_dvd[OLE_SHIFT_W-2:0], 1'b0};
                    r_step <= r_step - SCW'(1);
                    if (r_step == '0) begin
                        // rotate left by s: reverse [0,s), reverse [s,n), then reverse all
                        if (rem_next == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_shift <= rem_next[AW-1:0];
                            r_phase <= 2'd0;
                            r_lo    <= '0;
                            r_hi    <= rem_next[AW-1:0] - AW'(1);
                            r_state <= S_REV_CHK;
                        end
                    end
                end
                S_REV_CHK: begin
                    if (r_lo < r_hi) begin
                        r_state <= S_RLO;
                    end else begin
                        case (r_phase)
                            2'd0: begin
                                r_phase <= 2'd1;
                                r_lo    <= r_shift;
                                r_hi    <= last_idx;
                            end
                            2'd1: begin
                                r_phase <= 2'd2;
                                r_lo    <= '0;
                                r_hi    <= last_idx;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RLO: begin
                    r_state <= S_RHI;
                end
                S_RHI: begin
                    r_tmp   <= r_rd_data;
                    r_state <= S_WLO;
                end
                S_WLO: begin
                    r_state <= S_WHI;
                end
                S_WHI: begin
                    r_lo    <= r_lo + AW'(1);
                    r_hi    <= r_hi - AW'(1);
                    r_state <= S_REV_CHK;
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    r_k <= r_k - AW'(1);
                    if ((r_k - AW'(1)) > r_pos) begin
                        r_state <= S_SH_RD;
                    end else begin
                        r_state <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_DEL_RD: begin
                    r_state <= S_DEL_WR;
                end
                S_DEL_WR: begin
                    r_k <= r_k + AW'(1);
                    if ((k_ext + (CW+1)'(2)) < {1'b0, r_count}) begin
                        r_state <= S_DEL_RD;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_RD_WAIT: begin
                    r_state <= S_RD_TAKE;
                end
                S_RD_TAKE: begin
                    r_rd    <= r_rd_data;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold the result until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.entry_count <= cnt_x[4:0];
                        r_out.read_value  <= r_rd;
                        r_out.status      <= r_status;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `OLE_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "entry count above capacity")
    `OLE_ASSERT(a_insert_room, (r_state == S_INS_WR) |-> (r_count < CW'(CAPACITY)),
        "insert into full list")
    `OLE_ASSERT(a_div_rem, (r_state == S_DIV) |-> (r_rem < r_count),
        "divider remainder not below count")
    `OLE_ASSERT(a_swap_order, (r_state == S_RLO) |-> (r_lo < r_hi), "swap with crossed indices")
    `OLE_ASSERT_NEXT(a_result_load, (r_state == S_DONE) && !r_out_valid,
        o_out_valid && (r_state == S_IDLE), "finished result not loaded")

endmodule
